// ----- sv/uef_pkg.sv -----
package uef_pkg;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned DATA_W      = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- sv/uef_cell.sv -----
module uef_cell (
	input  logic                clk,
	input  uef_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  uef_pkg::data_t      push_value,
	input  uef_pkg::data_t      next_data,
	output uef_pkg::data_t      data,
	output logic                match
);

	uef_pkg::data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= push_value;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data  = data_q;
	assign match = occupied && (data_q == push_value);

endmodule

// ----- sv/unique_entry_fifo_core.sv -----
// channel   signals                                  direction
// request   in_valid, in_stall, op, value            in (in_stall out)
// result    out_valid, out_stall, added, duplicate,  out (out_stall in)
//           overflow, underflow, head_valid,
//           head_value, tail_value, entry_count
// one beat per cycle in while in_stall is low, result in the cycle after acceptance from a registered output stage.
// the duplicate check compares the value against every occupied cell of the chain in the same cycle.
// a pop shifts the whole chain one cell toward the head; a push loads the first free cell.
// reset clears occupancy and the result valid; cell contents stay undefined.
// in_stall is high only while a finished result is held by out_stall.
module unique_entry_fifo_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [uef_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                added,
	output logic                                duplicate,
	output logic                                overflow,
	output logic                                underflow,
	output logic                                head_valid,
	output logic signed [uef_pkg::DATA_W-1:0]   head_value,
	output logic signed [uef_pkg::DATA_W-1:0]   tail_value,
	output logic [uef_pkg::COUNT_W-1:0]         entry_count
);

	uef_pkg::cnt_t       occ_q;
	uef_pkg::data_t      tail_q;
	uef_pkg::data_t      cell_data [uef_pkg::QUEUE_DEPTH];
	uef_pkg::cell_ctrl_t cell_ctrl [uef_pkg::QUEUE_DEPTH];
	logic [uef_pkg::QUEUE_DEPTH-1:0] match_vec;

	logic                  out_valid_q;
	logic                  added_q;
	logic                  dup_q;
	logic                  ovf_q;
	logic                  udf_q;
	logic                  head_valid_q;
	uef_pkg::data_t        head_q;
	uef_pkg::data_t        tail_out_q;
	logic [uef_pkg::COUNT_W-1:0] count_q;

	logic           accept;
	logic           is_push;
	logic           dup_hit;
	logic           full;
	logic           empty;
	logic           do_add;
	logic           do_pop;
	uef_pkg::cnt_t  occ_next;
	uef_pkg::data_t head_next;
	uef_pkg::data_t tail_next;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_push  = (op == uef_pkg::OP_PUSH);
	assign dup_hit  = |match_vec;
	assign full     = (occ_q == uef_pkg::CNT_W'(uef_pkg::QUEUE_DEPTH));
	assign empty    = (occ_q == '0);
	assign do_add   = accept && is_push && !dup_hit && !full;
	assign do_pop   = accept && !is_push && !empty;

	always_comb begin
		occ_next = occ_q;
		if (do_add) begin
			occ_next = occ_q + 1'b1;
		end else if (do_pop) begin
			occ_next = occ_q - 1'b1;
		end
	end

	always_comb begin
		if (occ_next == '0) begin
			head_next = '0;
		end else if (do_add && empty) begin
			head_next = value;
		end else if (do_pop) begin
			head_next = cell_data[1];
		end else begin
			head_next = cell_data[0];
		end
	end

	always_comb begin
		if (occ_next == '0) begin
			tail_next = '0;
		end else if (do_add) begin
			tail_next = value;
		end else begin
			tail_next = tail_q;
		end
	end

	for (genvar i = 0; i < uef_pkg::QUEUE_DEPTH; i++) begin : g_cell
		uef_pkg::data_t next_d;
		logic           occupied;

		if (i == uef_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid
			assign next_d = cell_data[i+1];
		end

		assign occupied           = (uef_pkg::CNT_W'(i) < occ_q);
		// first free cell takes the pushed value
		assign cell_ctrl[i].load  = do_add && (occ_q == uef_pkg::CNT_W'(i));
		assign cell_ctrl[i].shift = do_pop;

		uef_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[i]),
			.occupied   (occupied),
			.push_value (value),
			.next_data  (next_d),
			.data       (cell_data[i]),
			.match      (match_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			tail_q <= value;
		end
		if (accept) begin
			added_q      <= do_add;
			dup_q        <= is_push && dup_hit;
			ovf_q        <= is_push && !dup_hit && full;
			udf_q        <= !is_push && empty;
			head_valid_q <= (occ_next != '0);
			head_q       <= head_next;
			tail_out_q   <= tail_next;
			count_q      <= uef_pkg::COUNT_W'(occ_next);
		end
	end

	assign out_valid   = out_valid_q;
	assign added       = added_q;
	assign duplicate   = dup_q;
	assign overflow    = ovf_q;
	assign underflow   = udf_q;
	assign head_valid  = head_valid_q;
	assign head_value  = head_q;
	assign tail_value  = tail_out_q;
	assign entry_count = count_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({added_q, dup_q, ovf_q, udf_q}))
		else $error("more than one outcome flag set");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= uef_pkg::CNT_W'(uef_pkg::QUEUE_DEPTH))
		else $error("occupancy beyond depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !head_valid_q) |-> (head_q == '0 && tail_out_q == '0))
		else $error("empty result carries nonzero values");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> (occ_q == $past(occ_q) + 1'b1))
		else $error("push did not grow occupancy");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |-> (!dup_hit && !full))
		else $error("push added a value already stored");

endmodule

// ----- verif/unique_entry_fifo_core_tb.sv -----
module unique_entry_fifo_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                          added;
		logic                          duplicate;
		logic                          overflow;
		logic                          underflow;
		logic                          head_valid;
		uef_pkg::data_t                head_value;
		uef_pkg::data_t                tail_value;
		logic [uef_pkg::COUNT_W-1:0]   entry_count;
	} fifo_status_t;

	class fifo_scoreboard;
		uef_pkg::data_t shadow_fifo[$];
		fifo_status_t   expected_status[$];
		int             errors;

		function new();
			errors = 0;
		endfunction

		// mirrors the block: duplicate test first, then the full test
		function void note_request(logic op_i, uef_pkg::data_t v);
			fifo_status_t s;
			bit           present;
			s = '0;
			present = 0;
			if (op_i == uef_pkg::OP_PUSH) begin
				foreach (shadow_fifo[i])
					if (shadow_fifo[i] == v) present = 1;
				if (present) begin
					s.duplicate = 1'b1;
				end else if (shadow_fifo.size() >= uef_pkg::QUEUE_DEPTH) begin
					s.overflow = 1'b1;
				end else begin
					shadow_fifo.push_back(v);
					s.added = 1'b1;
				end
			end else begin
				if (shadow_fifo.size() == 0) begin
					s.underflow = 1'b1;
				end else begin
					void'(shadow_fifo.pop_front());
				end
			end
			if (shadow_fifo.size() != 0) begin
				s.head_valid = 1'b1;
				s.head_value = shadow_fifo[0];
				s.tail_value = shadow_fifo[shadow_fifo.size() - 1];
			end
			s.entry_count = uef_pkg::COUNT_W'(shadow_fifo.size());
			expected_status.push_back(s);
		endfunction

		function void diff_field(string name, logic [uef_pkg::DATA_W-1:0] exp_v,
				logic [uef_pkg::DATA_W-1:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_status(fifo_status_t act);
			fifo_status_t exp_s;
			if (expected_status.size() == 0) begin
				$error("result beat with no request pending");
				errors++;
				return;
			end
			exp_s = expected_status.pop_front();
			diff_field("added", uef_pkg::DATA_W'(exp_s.added),
				uef_pkg::DATA_W'(act.added));
			diff_field("duplicate", uef_pkg::DATA_W'(exp_s.duplicate),
				uef_pkg::DATA_W'(act.duplicate));
			diff_field("overflow", uef_pkg::DATA_W'(exp_s.overflow),
				uef_pkg::DATA_W'(act.overflow));
			diff_field("underflow", uef_pkg::DATA_W'(exp_s.underflow),
				uef_pkg::DATA_W'(act.underflow));
			diff_field("head_valid", uef_pkg::DATA_W'(exp_s.head_valid),
				uef_pkg::DATA_W'(act.head_valid));
			diff_field("head_value", exp_s.head_value, act.head_value);
			diff_field("tail_value", exp_s.tail_value, act.tail_value);
			diff_field("entry_count", uef_pkg::DATA_W'(exp_s.entry_count),
				uef_pkg::DATA_W'(act.entry_count));
		endfunction

		function int pending();
			return expected_status.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        op;
	uef_pkg::data_t              value;
	logic                        out_valid;
	logic                        out_stall;
	logic                        added;
	logic                        duplicate;
	logic                        overflow;
	logic                        underflow;
	logic                        head_valid;
	uef_pkg::data_t              head_value;
	uef_pkg::data_t              tail_value;
	logic [uef_pkg::COUNT_W-1:0] entry_count;

	fifo_scoreboard sb;
	int             send_gap_pct;
	int             recv_stall_pct;
	bit             hold_req;
	uef_pkg::data_t value_pool[20];

	unique_entry_fifo_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.added       (added),
		.duplicate   (duplicate),
		.overflow    (overflow),
		.underflow   (underflow),
		.head_valid  (head_valid),
		.head_value  (head_value),
		.tail_value  (tail_value),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// entered and left at a falling edge; valid stays high from one beat to the next unless a random gap is drawn
	task automatic send_item(logic op_i, uef_pkg::data_t v);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_gap_pct) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= op_i;
		value    <= v;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_request(op_i, v);
		@(negedge clk);
	endtask

	task automatic refill_pool();
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = '0;
		value_pool[3] = '1;
		for (int i = 4; i < 20; i++) value_pool[i] = uef_pkg::data_t'($urandom);
	endtask

	// mostly a small pool so duplicates and a full store come up often
	function automatic uef_pkg::data_t pick_value();
		if ($urandom_range(9) < 7) return value_pool[$urandom_range(19)];
		return uef_pkg::data_t'($urandom);
	endfunction

	// receiver: random stall, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 200;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_status('{added, duplicate, overflow, underflow, head_valid,
					head_value, tail_value, entry_count});
		end
	end

	initial begin
		#2ms;
		$display("** unique_entry_fifo_core: FAILED **");
		$finish;
	end

	initial begin
		int seg_len;
		int push_pct;
		int left;
		sb = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = uef_pkg::OP_PUSH;
		value          = '0;
		hold_req       = 0;
		send_gap_pct   = 6;
		recv_stall_pct = 69;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pops, extremes, duplicate, back to empty
		send_item(uef_pkg::OP_POP, '0);
		send_item(uef_pkg::OP_PUSH, 32'sh8000_0000);
		send_item(uef_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_item(uef_pkg::OP_PUSH, 32'sh8000_0000);
		send_item(uef_pkg::OP_POP, '1);
		send_item(uef_pkg::OP_POP, '0);
		send_item(uef_pkg::OP_POP, '0);
		// fill to the brim, then overflow and a duplicate while full
		for (int k = 0; k < uef_pkg::QUEUE_DEPTH; k++)
			send_item(uef_pkg::OP_PUSH, uef_pkg::data_t'(k * 32'h1111_1111));
		send_item(uef_pkg::OP_PUSH, 32'sh8000_0000);
		send_item(uef_pkg::OP_PUSH, 32'sh7777_7777);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct   = 6;
					recv_stall_pct = 69;
				end
				1: begin
					send_gap_pct   = 69;
					recv_stall_pct = 6;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
					// long hold-off so the result stage backs up into the input
					in_valid <= 1'b0;
					@(posedge clk);
					hold_req = 1;
					@(negedge clk);
				end
			endcase
			left = 642;
			while (left > 0) begin
				refill_pool();
				seg_len = $urandom_range(20, 80);
				case ($urandom_range(3))
					0: push_pct = 30;
					1: push_pct = 50;
					2: push_pct = 65;
					default: push_pct = 85;
				endcase
				for (int i = 0; i < seg_len && left > 0; i++) begin
					if ($urandom_range(99) < push_pct)
						send_item(uef_pkg::OP_PUSH, pick_value());
					else
						send_item(uef_pkg::OP_POP, uef_pkg::data_t'($urandom));
					left--;
				end
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("** unique_entry_fifo_core: PASSED **");
		else
			$display("** unique_entry_fifo_core: FAILED **");
		$finish;
	end

endmodule
